// ===== hdl/fpa_pkg.sv =====
// Shared types and constants for the Q24.8 fixed-point ALU.
package fpa_pkg;

    localparam int FPA_PORT_BITS     = 32;
    localparam int FPA_WORD_BITS     = 32;
    localparam int FPA_FRACTION_BITS = 8;

    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_LT       = 4'd4,
        OP_GT       = 4'd5,
        OP_LE       = 4'd6,
        OP_GE       = 4'd7,
        OP_EQ       = 4'd8,
        OP_NE       = 4'd9,
        OP_MIN      = 4'd10,
        OP_MAX      = 4'd11,
        OP_INC      = 4'd12,
        OP_DEC      = 4'd13,
        OP_FROM_INT = 4'd14,
        OP_TO_INT   = 4'd15
    } fpa_op_t;

    typedef struct packed {
        logic valid;
        logic is_div;
        logic neg;
        logic dz;
    } fpa_ctl_t;

endpackage

// ===== hdl/fpa_if.sv =====
// Valid/ready channels for ALU operations and results.
interface fpa_op_if
    import fpa_pkg::*;
();
    logic                            valid;
    logic                            ready;
    logic [3:0]                      opcode;
    logic signed [FPA_PORT_BITS-1:0] operand_a;
    logic signed [FPA_PORT_BITS-1:0] operand_b;

    modport source (output valid, output opcode, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input opcode, input operand_a, input operand_b,
                    output ready);
endinterface

interface fpa_res_if
    import fpa_pkg::*;
();
    logic                            valid;
    logic                            ready;
    logic signed [FPA_PORT_BITS-1:0] result_value;
    logic                            divide_by_zero;

    modport source (output valid, output result_value, output divide_by_zero, input ready);
    modport sink   (input valid, input result_value, input divide_by_zero, output ready);
endinterface

// ===== hdl/fpa_front.sv =====
// Operand register, decode, multiply and simple operations; divider setup.
module fpa_front
    import fpa_pkg::*;
#(
    parameter int WORD_BITS     = FPA_WORD_BITS,
    parameter int FRACTION_BITS = FPA_FRACTION_BITS,
    localparam int N            = WORD_BITS + FRACTION_BITS
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [3:0]           in_opcode,
    input  logic signed [FPA_PORT_BITS-1:0] in_a,
    input  logic signed [FPA_PORT_BITS-1:0] in_b,
    output fpa_ctl_t             ctl,
    output logic [N-1:0]         num,
    output logic [WORD_BITS-1:0] divisor,
    output logic [WORD_BITS-1:0] alt
);

    logic                        valid_reg;
    fpa_op_t                     op_reg;
    logic signed [WORD_BITS-1:0] a_reg;
    logic signed [WORD_BITS-1:0] b_reg;

    logic signed [2*WORD_BITS-1:0] prod;
    logic [WORD_BITS-1:0]          mag_a;
    logic [WORD_BITS-1:0]          mag_b;
    logic [WORD_BITS-1:0]          tq;
    logic                          lt;
    logic                          gt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_reg <= fpa_op_t'(in_opcode);
            a_reg  <= WORD_BITS'(in_a);
            b_reg  <= WORD_BITS'(in_b);
        end
    end

    always_comb
    begin
        prod  = (2*WORD_BITS)'(a_reg) * (2*WORD_BITS)'(b_reg);
        mag_a = a_reg[WORD_BITS-1] ? WORD_BITS'(-a_reg) : a_reg;
        mag_b = b_reg[WORD_BITS-1] ? WORD_BITS'(-b_reg) : b_reg;
        tq    = mag_a >> FRACTION_BITS;
        lt    = a_reg < b_reg;
        gt    = b_reg < a_reg;
        case (op_reg)
            OP_ADD:      alt = a_reg + b_reg;
            OP_SUB:      alt = a_reg - b_reg;
            OP_MUL:      alt = prod[FRACTION_BITS +: WORD_BITS];
            OP_LT:       alt = WORD_BITS'(lt);
            OP_GT:       alt = WORD_BITS'(gt);
            OP_LE:       alt = WORD_BITS'(!gt);
            OP_GE:       alt = WORD_BITS'(!lt);
            OP_EQ:       alt = WORD_BITS'(a_reg == b_reg);
            OP_NE:       alt = WORD_BITS'(a_reg != b_reg);
            OP_MIN:      alt = lt ? a_reg : b_reg;
            OP_MAX:      alt = gt ? a_reg : b_reg;
            OP_INC:      alt = a_reg + WORD_BITS'(1);
            OP_DEC:      alt = a_reg - WORD_BITS'(1);
            OP_FROM_INT: alt = a_reg << FRACTION_BITS;
            OP_TO_INT:   alt = a_reg[WORD_BITS-1] ? WORD_BITS'(-tq) : tq;
            default:     alt = '0;
        endcase
        ctl.valid  = valid_reg;
        ctl.is_div = (op_reg == OP_DIV);
        ctl.neg    = a_reg[WORD_BITS-1] ^ b_reg[WORD_BITS-1];
        ctl.dz     = (op_reg == OP_DIV) && (b_reg == '0);
        num        = {{FRACTION_BITS{1'b0}}, mag_a} << FRACTION_BITS;
        divisor    = mag_b;
    end

endmodule

// ===== hdl/fpa_cell.sv =====
// One divider cell: one restoring quotient bit, carries the item along.
module fpa_cell
    import fpa_pkg::*;
#(
    parameter int WORD_BITS     = FPA_WORD_BITS,
    parameter int FRACTION_BITS = FPA_FRACTION_BITS,
    localparam int N            = WORD_BITS + FRACTION_BITS
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  fpa_ctl_t             ctl_in,
    input  logic [WORD_BITS-1:0] rem_in,
    input  logic [N-1:0]         num_in,
    input  logic [WORD_BITS-1:0] quo_in,
    input  logic [WORD_BITS-1:0] div_in,
    input  logic [WORD_BITS-1:0] alt_in,
    output fpa_ctl_t             ctl_out,
    output logic [WORD_BITS-1:0] rem_out,
    output logic [N-1:0]         num_out,
    output logic [WORD_BITS-1:0] quo_out,
    output logic [WORD_BITS-1:0] div_out,
    output logic [WORD_BITS-1:0] alt_out
);

    fpa_ctl_t             ctl_reg;
    logic [WORD_BITS-1:0] rem_reg, rem_next;
    logic [N-1:0]         num_reg;
    logic [WORD_BITS-1:0] quo_reg, quo_next;
    logic [WORD_BITS-1:0] div_reg;
    logic [WORD_BITS-1:0] alt_reg;
    logic [WORD_BITS:0]   trial;
    logic [WORD_BITS:0]   diff;
    logic                 ge;

    always_comb
    begin
        trial    = {rem_in, num_in[N-1]};
        diff     = trial - {1'b0, div_in};
        ge       = trial >= {1'b0, div_in};
        rem_next = ge ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
        quo_next = {quo_in[WORD_BITS-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            num_reg <= num_in << 1;
            quo_reg <= quo_next;
            div_reg <= div_in;
            alt_reg <= alt_in;
        end
    end

    assign ctl_out = ctl_reg;
    assign rem_out = rem_reg;
    assign num_out = num_reg;
    assign quo_out = quo_reg;
    assign div_out = div_reg;
    assign alt_out = alt_reg;

endmodule

// ===== hdl/fpa_back.sv =====
// Quotient sign fix, result select and output register.
module fpa_back
    import fpa_pkg::*;
#(
    parameter int WORD_BITS = FPA_WORD_BITS
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  fpa_ctl_t             ctl,
    input  logic [WORD_BITS-1:0] quo,
    input  logic [WORD_BITS-1:0] alt,
    output logic                 valid,
    output logic signed [FPA_PORT_BITS-1:0] value,
    output logic                 dz
);

    logic                              valid_reg;
    logic signed [FPA_PORT_BITS-1:0]   value_reg, value_next;
    logic                              dz_reg;
    logic signed [WORD_BITS-1:0]       r;

    always_comb
    begin
        if (!ctl.is_div)
        begin
            r = alt;
        end
        else if (ctl.dz)
        begin
            r = '0;
        end
        else
        begin
            r = ctl.neg ? WORD_BITS'(-quo) : quo;
        end
        value_next = FPA_PORT_BITS'(r);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            value_reg <= value_next;
            dz_reg    <= ctl.dz;
        end
    end

    assign valid = valid_reg;
    assign value = value_reg;
    assign dz    = dz_reg;

endmodule

// ===== hdl/fixed_point_alu_q24_8.sv =====
// Top level of the signed Q24.8 fixed-point ALU.
// One operation is accepted every cycle; each passes the operand register,
// a row of one-bit restoring divider cells that every item passes through,
// and the output register. The whole pipe stalls only while a finished
// result is not taken.
module fixed_point_alu_q24_8
    import fpa_pkg::*;
#(
    parameter int WORD_BITS     = FPA_WORD_BITS,
    parameter int FRACTION_BITS = FPA_FRACTION_BITS
)(
    input  logic      clk,
    input  logic      rst_n,
    fpa_op_if.sink    operation,
    fpa_res_if.source outcome
);

    localparam int N = WORD_BITS + FRACTION_BITS;

    logic en;
    logic out_valid;

    fpa_ctl_t             ctl_s [0:N];
    logic [WORD_BITS-1:0] rem_s [0:N];
    logic [N-1:0]         num_s [0:N];
    logic [WORD_BITS-1:0] quo_s [0:N];
    logic [WORD_BITS-1:0] div_s [0:N];
    logic [WORD_BITS-1:0] alt_s [0:N];

    assign en              = !out_valid || outcome.ready;
    assign operation.ready = en;
    assign outcome.valid   = out_valid;
    assign rem_s[0]        = '0;
    assign quo_s[0]        = '0;

    fpa_front #(
        .WORD_BITS     (WORD_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (operation.valid),
        .in_opcode (operation.opcode),
        .in_a      (operation.operand_a),
        .in_b      (operation.operand_b),
        .ctl       (ctl_s[0]),
        .num       (num_s[0]),
        .divisor   (div_s[0]),
        .alt       (alt_s[0])
    );

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        fpa_cell #(
            .WORD_BITS     (WORD_BITS),
            .FRACTION_BITS (FRACTION_BITS)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .ctl_in  (ctl_s[i]),
            .rem_in  (rem_s[i]),
            .num_in  (num_s[i]),
            .quo_in  (quo_s[i]),
            .div_in  (div_s[i]),
            .alt_in  (alt_s[i]),
            .ctl_out (ctl_s[i+1]),
            .rem_out (rem_s[i+1]),
            .num_out (num_s[i+1]),
            .quo_out (quo_s[i+1]),
            .div_out (div_s[i+1]),
            .alt_out (alt_s[i+1])
        );
    end

    fpa_back #(
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .ctl   (ctl_s[N]),
        .quo   (quo_s[N]),
        .alt   (alt_s[N]),
        .valid (out_valid),
        .value (outcome.result_value),
        .dz    (outcome.divide_by_zero)
    );

endmodule
